>>> design/ple_pkg.sv
// ---------------------------------------------------------------------------
// ple_pkg: shared types and constants for the positional list engine
// Request kinds, status codes, sequencer states and the result bundle
// passed from the sequencer to the response stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ple_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int VALUE_W      = 32;
   localparam int POS_W        = 8;
   localparam int KIND_W       = 3;
   localparam int LEN_W        = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_FRONT  = 3'd0,
      KIND_AT     = 3'd1,
      KIND_APPEND = 3'd2,
      KIND_DELETE = 3'd3,
      KIND_READ   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_BAD  = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INS,
      OP_DEL,
      OP_RD
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PUT,
      ST_TRIM,
      ST_DONE
   } state_type;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  read_value;
      logic [LEN_W-1:0]           length;
   } result_type;

endpackage

>>> design/positional_list_engine.sv
// ---------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit entries
// Insert, append, delete and read by position, one request at a time.
// ---------------------------------------------------------------------------
// One request is taken at a time; req_ready is high only while the engine
// is idle. An insert or delete moves each entry between its position and
// the end of the list by one place, and any request may wait for the
// response slot. The sequencer never reads and writes the entry memory in
// the same cycle: each moved entry costs one read and then one write, walked
// by one shared index step unit. The response register frees the engine as
// soon as a result is loaded, even while it waits on rsp_ready.
`timescale 1ns / 1ps

module positional_list_engine #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ple_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [ple_pkg::VALUE_W-1:0]  req_value,
   input  logic signed [ple_pkg::POS_W-1:0]    req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic signed [ple_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [ple_pkg::LEN_W-1:0]           rsp_length
);
   import ple_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic                res_valid;
   result_type          res_data;
   logic                res_free;
   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   logic [VALUE_W-1:0]  mem_wr_data;
   logic                mem_rd_en;
   logic [AW-1:0]       mem_rd_addr;
   logic [VALUE_W-1:0]  mem_rd_data;

   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_data_ff, rsp_data_in;

   ple_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .req_position (req_position),
      .res_valid    (res_valid),
      .res_data     (res_data),
      .res_free     (res_free),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   ple_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // response register: loads when empty or being drained this cycle
   assign res_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_free) begin
         rsp_valid_in = res_valid;
         if (res_valid) rsp_data_in = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_read_value = rsp_data_ff.read_value;
   assign rsp_length     = rsp_data_ff.length;

endmodule

>>> design/ple_store.sv
// ---------------------------------------------------------------------------
// ple_store: entry memory
// Single write port, single read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ple_store #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(CAPACITY)-1:0]         wr_addr,
   input  logic [ple_pkg::VALUE_W-1:0]         wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(CAPACITY)-1:0]         rd_addr,
   output logic [ple_pkg::VALUE_W-1:0]         rd_data
);
   import ple_pkg::*;

   logic [VALUE_W-1:0] entries_ff [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ple_seq.sv
// ---------------------------------------------------------------------------
// ple_seq: request sequencer
// Checks each request, reads one entry or walks the memory one place at a
// time with a shared index step unit to open or close a gap, then replies.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ple_seq #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ple_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [ple_pkg::VALUE_W-1:0]  req_value,
   input  logic signed [ple_pkg::POS_W-1:0]    req_position,
   output logic                                res_valid,
   output ple_pkg::result_type                 res_data,
   input  logic                                res_free,
   output logic                                mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]         mem_wr_addr,
   output logic [ple_pkg::VALUE_W-1:0]         mem_wr_data,
   output logic                                mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0]         mem_rd_addr,
   input  logic [ple_pkg::VALUE_W-1:0]         mem_rd_data
);
   import ple_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POS_W - 1) ? CW : POS_W - 1;

   state_type           state_ff, state_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       limit_ff, limit_in;
   logic                dir_ff, dir_in;       // 1: walk down (insert)
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [CW-1:0]       count_ff, count_in;
   status_type          status_ff, status_in;
   logic [VALUE_W-1:0]  rd_ff, rd_in;

   // request decode
   op_type              dec_op;
   status_type          dec_status;
   logic [AW-1:0]       dec_at;
   logic [XW-1:0]       pos_x;
   logic [XW-1:0]       cnt_x;
   logic                pos_neg;
   logic                full;
   logic                accept;

   // shared index step unit
   logic [AW-1:0]       src;
   logic                hit;

   assign pos_neg = req_position[POS_W-1];
   assign pos_x   = XW'(req_position[POS_W-2:0]);
   assign cnt_x   = XW'(count_ff);
   assign full    = (count_ff == CW'(CAPACITY));
   assign accept  = req_valid && req_ready;

   assign src = dir_ff ? (idx_ff - AW'(1)) : (idx_ff + AW'(1));
   assign hit = (src == limit_ff);

   // classify the request against the current length
   always_comb begin
      dec_op     = OP_NONE;
      dec_status = STAT_OK;
      dec_at     = '0;
      unique case (kind_type'(req_kind))
         KIND_FRONT: begin
            if (full) dec_status = STAT_FULL;
            else      dec_op     = OP_INS;
         end
         KIND_AT: begin
            if (pos_neg || (pos_x > cnt_x)) begin
               dec_status = STAT_BAD;
            end else if (full) begin
               dec_status = STAT_FULL;
            end else begin
               dec_op = OP_INS;
               dec_at = pos_x[AW-1:0];
            end
         end
         KIND_APPEND: begin
            if (full) begin
               dec_status = STAT_FULL;
            end else begin
               dec_op = OP_INS;
               dec_at = AW'(count_ff);
            end
         end
         KIND_DELETE: begin
            if (pos_neg || (pos_x >= cnt_x)) dec_status = STAT_BAD;
            else                             dec_op     = OP_DEL;
         end
         KIND_READ: begin
            if (pos_neg || (pos_x >= cnt_x)) dec_status = STAT_BAD;
            else                             dec_op     = OP_RD;
         end
         default: dec_status = STAT_BAD;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (dec_op)
                  OP_INS:  state_in = (AW'(count_ff) == dec_at) ? ST_PUT : ST_SHIFT_RD;
                  OP_DEL:  state_in = (pos_x == cnt_x - XW'(1)) ? ST_TRIM : ST_SHIFT_RD;
                  OP_RD:   state_in = ST_FETCH;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_FETCH:    state_in = ST_LOAD;
         ST_LOAD:     state_in = ST_DONE;
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: begin
            if (hit) state_in = dir_ff ? ST_PUT : ST_TRIM;
            else     state_in = ST_SHIFT_RD;
         end
         ST_PUT:      state_in = ST_DONE;
         ST_TRIM:     state_in = ST_DONE;
         ST_DONE:     if (res_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs: handshake and memory port controls
   always_comb begin
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_ff;
      unique case (state_ff)
         ST_IDLE:     req_ready = 1'b1;
         ST_FETCH:    mem_rd_en = 1'b1;
         ST_SHIFT_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = src;
         end
         ST_SHIFT_WR: mem_wr_en = 1'b1;
         ST_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = limit_ff;
            mem_wr_data = value_ff;
         end
         ST_DONE:     res_valid = 1'b1;
         default:     ;
      endcase
   end

   assign res_data.status     = status_ff;
   assign res_data.read_value = rd_ff;
   assign res_data.length     = LEN_W'(count_ff);

   // datapath registers
   always_comb begin
      idx_in    = idx_ff;
      limit_in  = limit_ff;
      dir_in    = dir_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      status_in = status_ff;
      rd_in     = rd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in  = req_value;
               status_in = dec_status;
               rd_in     = '0;
               if (dec_op == OP_INS) begin
                  idx_in   = AW'(count_ff);
                  limit_in = dec_at;
                  dir_in   = 1'b1;
               end else begin
                  idx_in   = pos_x[AW-1:0];
                  limit_in = AW'(count_ff - CW'(1));
                  dir_in   = 1'b0;
               end
            end
         end
         ST_LOAD:     rd_in    = mem_rd_data;
         ST_SHIFT_WR: idx_in   = src;
         ST_PUT:      count_in = count_ff + CW'(1);
         ST_TRIM:     count_in = count_ff - CW'(1);
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      limit_ff  <= limit_in;
      dir_ff    <= dir_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      rd_ff     <= rd_in;
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_single_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("memory read and write in the same cycle");

   a_shift_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT_WR) |-> $past(mem_rd_en))
      else $error("shift write without a preceding read");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_PUT && state_ff != ST_TRIM) |=> $stable(count_ff))
      else $error("entry count changed outside put or trim");

endmodule
